// File: hw/rtl/blra_pkg.sv
// Package: shared constants and types of the block list region allocator.
`timescale 1ns / 1ps
package blra_pkg;
    localparam int SLOTS       = 64;
    localparam int ALIGN_BYTES = 32;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int PTR_W       = IDX_W + 1;
    localparam int ALIGN_W     = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_ALLOC_HEAD = 2'd0,
        OP_ALLOC_TAIL = 2'd1,
        OP_FREE       = 2'd2,
        OP_INIT       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_HDL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_GROUP = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SLOT,
        S_APPLY,
        S_APPLY2,
        S_FREE_RD,
        S_FREE_WR,
        S_SUM,
        S_DONE
    } state_t;
endpackage

// File: hw/rtl/blra_if.sv
// Interfaces: input and result channels of the block list region allocator.
`timescale 1ns / 1ps
interface blra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [5:0]  block_handle;
    modport source (output valid, operation, request_size, block_handle, input ready);
    modport sink   (input valid, operation, request_size, block_handle, output ready);
endinterface

interface blra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  new_handle;
    logic [31:0] block_address;
    logic [31:0] granted_size;
    logic [31:0] largest_free;
    logic [31:0] total_free;
    modport source (output valid, status, new_handle, block_address, granted_size,
                    largest_free, total_free, input ready);
    modport sink   (input valid, status, new_handle, block_address, granted_size,
                    largest_free, total_free, output ready);
endinterface

// File: hw/rtl/block_list_region_allocator_top.sv
// Top level: sequencer, slot table and result register of the region allocator.
//
//   Channel | Direction | Content
//   req     | in        | operation, request_size, block_handle
//   rsp     | out       | status, new_handle, block_address, granted_size, free totals
//   cfg     | in        | cfg_we, cfg_index, cfg_data (region_base, region_size, group_id)
//
// Each transaction is worked by a small sequencer. In an allocation, the fit scan
// examines the chained blocks at one a cycle, the free-slot search steps over occupied
// slot indices at one a cycle, and the free-space totals walk then reads each of the
// chained blocks in turn. A free, an init and a request that is turned away before
// any scan also end with the totals walk. Reset empties the chain and clears the
// valid bits at once. The block takes a new transaction only when idle and its
// result register is empty; a stalled result holds its value until taken.
`timescale 1ns / 1ps
module block_list_region_allocator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    blra_req_if.sink     req,
    blra_rsp_if.source   rsp
);
    localparam int IW = blra_pkg::IDX_W;
    localparam int PW = blra_pkg::PTR_W;
    localparam logic [PW-1:0] NIL = blra_pkg::NIL;

    // Slot table held as memories; only valid bits and chain ends are flip-flops.
    logic [31:0]   mem_addr [blra_pkg::SLOTS];
    logic [31:0]   mem_used [blra_pkg::SLOTS];
    logic [31:0]   mem_free [blra_pkg::SLOTS];
    logic [PW-1:0] mem_next [blra_pkg::SLOTS];
    logic [PW-1:0] mem_prev [blra_pkg::SLOTS];
    logic [7:0]    mem_group [blra_pkg::SLOTS];
    logic          mem_temp  [blra_pkg::SLOTS];

    logic [blra_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;

    logic [31:0] base_reg, size_reg;
    logic [7:0]  group_reg;

    blra_pkg::state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [32:0] sz_reg, sz_next;
    logic [IW-1:0] hdl_reg, hdl_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] pick_reg, pick_next;
    logic [31:0] best_reg, best_next;
    logic [PW:0] guard_reg, guard_next;
    logic [PW-1:0] slot_reg, slot_next;
    logic [31:0] big_reg, big_next, sum_reg, sum_next;

    // Registered read port: the sequencer presents an address, data arrives next cycle.
    logic [IW-1:0] rd_idx;
    logic [31:0]   rd_addr, rd_used, rd_free;
    logic [PW-1:0] rd_nxt, rd_prv;

    // Pick record latched when the scan finds a fit, and free-phase record.
    logic [31:0]   pk_addr_reg, pk_used_reg, pk_free_reg;
    logic [PW-1:0] pk_next_reg, pk_prev_reg;
    logic          pk_load;

    logic          out_valid_reg;
    logic [1:0]    o_status_reg, o_status_next;
    logic [5:0]    o_handle_reg, o_handle_next;
    logic [31:0]   o_addr_reg, o_addr_next, o_grant_reg, o_grant_next;
    logic          out_load;

    // One main write port plus separate free-space, next-link and prev-link write ports.
    logic          w_en;
    logic [IW-1:0] w_idx;
    logic [31:0]   w_addr, w_used, w_free;
    logic [PW-1:0] w_nxt, w_prv;
    logic          w_temp;
    logic [7:0]    w_group;
    logic          w_full;
    logic          wf_en;
    logic [IW-1:0] wf_idx;
    logic [31:0]   wf_free;
    logic          wn_en, wp_en;
    logic [IW-1:0] wn_idx, wp_idx;
    logic [PW-1:0] wn_val, wp_val;

    logic [31:0] new_free_pick;
    logic [31:0] new_addr;
    logic        fits_head, fits_tail;

    always_ff @(posedge clk)
    begin
        rd_addr <= mem_addr[rd_idx];
        rd_used <= mem_used[rd_idx];
        rd_free <= mem_free[rd_idx];
        rd_nxt  <= mem_next[rd_idx];
        rd_prv  <= mem_prev[rd_idx];
        if (w_en)
        begin
            if (w_full)
            begin
                mem_addr[w_idx]  <= w_addr;
                mem_used[w_idx]  <= w_used;
                mem_next[w_idx]  <= w_nxt;
                mem_prev[w_idx]  <= w_prv;
                mem_group[w_idx] <= w_group;
                mem_temp[w_idx]  <= w_temp;
            end
            else
            begin
                mem_used[w_idx] <= w_used;
            end
            mem_free[w_idx] <= w_free;
        end
        if (wf_en)
        begin
            mem_free[wf_idx] <= wf_free;
        end
        if (wn_en)
        begin
            mem_next[wn_idx] <= wn_val;
        end
        if (wp_en)
        begin
            mem_prev[wp_idx] <= wp_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pk_load)
        begin
            pk_addr_reg <= rd_addr;
            pk_used_reg <= rd_used;
            pk_free_reg <= rd_free;
            pk_next_reg <= rd_nxt;
            pk_prev_reg <= rd_prv;
        end
        o_status_reg <= o_status_next;
        o_handle_reg <= o_handle_next;
        o_addr_reg   <= o_addr_next;
        o_grant_reg  <= o_grant_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blra_pkg::S_IDLE;
            valid_reg     <= '0;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            base_reg      <= '0;
            size_reg      <= '0;
            group_reg     <= 8'hff;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    blra_pkg::CFG_BASE:  base_reg  <= cfg_data;
                    blra_pkg::CFG_SIZE:  size_reg  <= cfg_data;
                    blra_pkg::CFG_GROUP: group_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        sz_reg    <= sz_next;
        hdl_reg   <= hdl_next;
        cur_reg   <= cur_next;
        pick_reg  <= pick_next;
        best_reg  <= best_next;
        guard_reg <= guard_next;
        slot_reg  <= slot_next;
        big_reg   <= big_next;
        sum_reg   <= sum_next;
    end

    assign fits_head = (sz_reg[31:0] <= rd_free) && (rd_free < best_reg);
    assign fits_tail = (rd_free >= sz_reg[31:0]);
    assign new_free_pick = pk_free_reg - sz_reg[31:0];
    assign new_addr = (op_reg == blra_pkg::OP_ALLOC_HEAD)
                    ? pk_addr_reg + pk_used_reg
                    : pk_addr_reg + pk_used_reg + new_free_pick;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sz_next       = sz_reg;
        hdl_next      = hdl_reg;
        cur_next      = cur_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        guard_next    = guard_reg;
        slot_next     = slot_reg;
        big_next      = big_reg;
        sum_next      = sum_reg;
        valid_next    = valid_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        rd_idx        = cur_reg[IW-1:0];
        pk_load       = 1'b0;
        out_load      = 1'b0;
        o_status_next = o_status_reg;
        o_handle_next = o_handle_reg;
        o_addr_next   = o_addr_reg;
        o_grant_next  = o_grant_reg;
        w_en = 1'b0; w_full = 1'b0; w_idx = '0; w_addr = '0; w_used = '0;
        w_free = '0; w_nxt = NIL; w_prv = NIL; w_temp = 1'b0; w_group = group_reg;
        wf_en = 1'b0; wf_idx = '0; wf_free = '0;
        wn_en = 1'b0; wn_idx = '0; wn_val = NIL;
        wp_en = 1'b0; wp_idx = '0; wp_val = NIL;
        req.ready = 1'b0;

        unique case (state_reg)
            blra_pkg::S_IDLE:
            begin
                req.ready = !out_valid_reg;
                if (req.valid && !out_valid_reg)
                begin
                    op_next  = req.operation;
                    hdl_next = req.block_handle[IW-1:0];
                    sz_next  = ({1'b0, req.request_size} + 33'(blra_pkg::ALIGN_BYTES - 1))
                             & ~33'(blra_pkg::ALIGN_BYTES - 1);
                    pick_next  = NIL;
                    best_next  = 32'hffffffff;
                    guard_next = '0;
                    o_handle_next = '0;
                    o_addr_next   = '0;
                    o_grant_next  = '0;
                    o_status_next = blra_pkg::ST_OK;
                    case (req.operation)
                        blra_pkg::OP_ALLOC_HEAD: cur_next = head_reg;
                        blra_pkg::OP_ALLOC_TAIL: cur_next = tail_reg;
                        blra_pkg::OP_FREE:       cur_next = {1'b0, req.block_handle[IW-1:0]};
                        default:                 cur_next = NIL;
                    endcase
                    rd_idx = cur_next[IW-1:0];
                    case (req.operation) inside
                        blra_pkg::OP_ALLOC_HEAD, blra_pkg::OP_ALLOC_TAIL:
                        begin
                            if (cur_next == NIL || sz_next[32])
                            begin
                                o_status_next = blra_pkg::ST_NO_FIT;
                                cur_next   = head_reg;
                                state_next = blra_pkg::S_SUM;
                            end
                            else
                            begin
                                state_next = blra_pkg::S_SCAN;
                            end
                        end
                        blra_pkg::OP_FREE:
                        begin
                            if (!valid_reg[req.block_handle[IW-1:0]])
                            begin
                                o_status_next = blra_pkg::ST_BAD_HDL;
                                cur_next   = head_reg;
                                state_next = blra_pkg::S_SUM;
                            end
                            else
                            begin
                                state_next = blra_pkg::S_FREE_RD;
                            end
                        end
                        default:
                        begin
                            w_en = 1'b1; w_full = 1'b1; w_idx = '0;
                            w_addr = (base_reg + 32'(blra_pkg::ALIGN_BYTES - 1))
                                   & ~32'(blra_pkg::ALIGN_BYTES - 1);
                            w_free = size_reg & ~32'(blra_pkg::ALIGN_BYTES - 1);
                            w_group = 8'hff;
                            valid_next = '0;
                            valid_next[0] = 1'b1;
                            head_next = '0;
                            tail_next = '0;
                            cur_next   = '0;
                            state_next = blra_pkg::S_SUM;
                        end
                    endcase
                    big_next = '0;
                    sum_next = '0;
                end
            end

            blra_pkg::S_SCAN:
            begin
                // rd_* holds slot cur_reg.
                logic hit, stop;
                logic [PW-1:0] nx;
                hit  = (op_reg == blra_pkg::OP_ALLOC_HEAD) ? fits_head : fits_tail;
                stop = 1'b0;
                nx   = (op_reg == blra_pkg::OP_ALLOC_HEAD) ? rd_nxt : rd_prv;
                if (hit)
                begin
                    pick_next = cur_reg;
                    best_next = rd_free;
                    pk_load   = 1'b1;
                    if (op_reg == blra_pkg::OP_ALLOC_TAIL || rd_free == sz_reg[31:0])
                    begin
                        stop = 1'b1;
                    end
                end
                guard_next = guard_reg + 1'b1;
                if (nx == NIL || guard_next >= (PW+1)'(blra_pkg::SLOTS))
                begin
                    stop = 1'b1;
                end
                cur_next = nx;
                rd_idx   = nx[IW-1:0];
                if (stop)
                begin
                    if (!hit && pick_reg == NIL)
                    begin
                        o_status_next = blra_pkg::ST_NO_FIT;
                        cur_next   = head_reg;
                        guard_next = '0;
                        state_next = blra_pkg::S_SUM;
                    end
                    else
                    begin
                        slot_next  = '0;
                        state_next = blra_pkg::S_SLOT;
                    end
                    rd_idx = cur_next[IW-1:0];
                end
            end

            blra_pkg::S_SLOT:
            begin
                // Lowest free slot, one index a cycle.
                if (slot_reg == NIL)
                begin
                    o_status_next = blra_pkg::ST_FULL;
                    cur_next   = head_reg;
                    guard_next = '0;
                    state_next = blra_pkg::S_SUM;
                end
                else if (!valid_reg[slot_reg[IW-1:0]])
                begin
                    state_next = blra_pkg::S_APPLY;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                rd_idx = cur_next[IW-1:0];
            end

            blra_pkg::S_APPLY:
            begin
                w_en = 1'b1; w_full = 1'b1; w_idx = slot_reg[IW-1:0];
                w_addr = new_addr;
                w_used = sz_reg[31:0];
                w_free = (op_reg == blra_pkg::OP_ALLOC_HEAD) ? new_free_pick : 32'd0;
                w_temp = (op_reg == blra_pkg::OP_ALLOC_TAIL);
                w_prv  = pick_reg;
                w_nxt  = pk_next_reg;
                wf_en = 1'b1; wf_idx = pick_reg[IW-1:0];
                wf_free = (op_reg == blra_pkg::OP_ALLOC_HEAD) ? 32'd0 : new_free_pick;
                wn_en = 1'b1; wn_idx = pick_reg[IW-1:0]; wn_val = slot_reg;
                if (pk_next_reg != NIL)
                begin
                    wp_en = 1'b1; wp_idx = pk_next_reg[IW-1:0]; wp_val = slot_reg;
                end
                else
                begin
                    tail_next = slot_reg;
                end
                valid_next[slot_reg[IW-1:0]] = 1'b1;
                o_handle_next = 6'(slot_reg[IW-1:0]);
                o_addr_next   = new_addr;
                o_grant_next  = sz_reg[31:0];
                state_next    = blra_pkg::S_APPLY2;
            end

            blra_pkg::S_APPLY2:
            begin
                cur_next   = head_reg;
                guard_next = '0;
                rd_idx     = head_reg[IW-1:0];
                state_next = blra_pkg::S_SUM;
            end

            blra_pkg::S_FREE_RD:
            begin
                // rd_* holds the freed slot; fetch its predecessor next.
                pk_load    = 1'b1;
                cur_next   = rd_prv;
                rd_idx     = rd_prv[IW-1:0];
                state_next = blra_pkg::S_FREE_WR;
            end

            blra_pkg::S_FREE_WR:
            begin
                if (pk_prev_reg == NIL)
                begin
                    w_en = 1'b1; w_idx = hdl_reg;
                    w_free = pk_free_reg + pk_used_reg;
                    w_used = '0;
                end
                else
                begin
                    wf_en = 1'b1; wf_idx = pk_prev_reg[IW-1:0];
                    wf_free = rd_free + pk_used_reg + pk_free_reg;
                    wn_en = 1'b1; wn_idx = pk_prev_reg[IW-1:0]; wn_val = pk_next_reg;
                    if (pk_next_reg != NIL)
                    begin
                        wp_en = 1'b1; wp_idx = pk_next_reg[IW-1:0]; wp_val = pk_prev_reg;
                    end
                    else
                    begin
                        tail_next = pk_prev_reg;
                    end
                    valid_next[hdl_reg] = 1'b0;
                end
                state_next = blra_pkg::S_APPLY2;
            end

            blra_pkg::S_SUM:
            begin
                // First cycle here only waits for the read of cur_reg, unless nil.
                if (cur_reg == NIL || guard_reg >= (PW+1)'(blra_pkg::SLOTS))
                begin
                    state_next = blra_pkg::S_DONE;
                end
                else
                begin
                    state_next = blra_pkg::S_DONE;
                    rd_idx     = cur_reg[IW-1:0];
                    if (guard_reg[PW] == 1'b0 && guard_reg != '1)
                    begin
                        state_next = blra_pkg::S_SUM;
                    end
                    // Accumulate when the data for cur_reg is present (odd phase).
                    if (slot_reg == NIL)
                    begin
                        if (rd_free > big_reg)
                        begin
                            big_next = rd_free;
                        end
                        sum_next   = sum_reg + rd_free;
                        guard_next = guard_reg + 1'b1;
                        cur_next   = rd_nxt;
                        slot_next  = '0;
                    end
                    else
                    begin
                        slot_next = NIL;
                    end
                end
            end

            blra_pkg::S_DONE:
            begin
                out_load   = 1'b1;
                state_next = blra_pkg::S_IDLE;
            end

            default: state_next = blra_pkg::S_IDLE;
        endcase
        if (state_reg != blra_pkg::S_SUM && state_next == blra_pkg::S_SUM)
        begin
            slot_next = '0;
            big_next  = '0;
            sum_next  = '0;
        end
    end

    logic [31:0] o_big_reg, o_sum_reg;
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_big_reg <= big_reg;
            o_sum_reg <= sum_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.new_handle    = o_handle_reg;
    assign rsp.block_address = o_addr_reg;
    assign rsp.granted_size  = o_grant_reg;
    assign rsp.largest_free  = o_big_reg;
    assign rsp.total_free    = o_sum_reg;

    // A result is only loaded from the final sequencer state.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == blra_pkg::S_DONE)
        else $error("result loaded outside done state");
    // Input is only taken while no result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !out_valid_reg)
        else $error("request taken with result pending");
    // The chain head, once set, always names a valid slot.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != NIL) |-> valid_reg[head_reg[IW-1:0]])
        else $error("chain head names an invalid slot");
endmodule
